FILE: design/cbt_pkg.sv
package cbt_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_JUMP_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEG1_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEG2_LENGTH = 2'd2;

  localparam logic [2:0] JUMP_WIDTH_MIN  = 3'd1;
  localparam logic [2:0] JUMP_WIDTH_MAX  = 3'd4;
  localparam logic [2:0] JUMP_WIDTH_RST  = 3'd1;
  localparam logic [4:0] SEG1_LENGTH_MIN = 5'd1;
  localparam logic [4:0] SEG1_LENGTH_MAX = 5'd16;
  localparam logic [4:0] SEG1_LENGTH_RST = 5'd8;
  localparam logic [3:0] SEG2_LENGTH_MIN = 4'd1;
  localparam logic [3:0] SEG2_LENGTH_MAX = 4'd8;
  localparam logic [3:0] SEG2_LENGTH_RST = 4'd2;

  // bit segment codes
  localparam logic [2:0] SEG_SYNC   = 3'd0;
  localparam logic [2:0] SEG_TSEG1  = 3'd1;
  localparam logic [2:0] SEG_LONG1  = 3'd2;
  localparam logic [2:0] SEG_TSEG2  = 3'd3;
  localparam logic [2:0] SEG_SHORT2 = 3'd4;

  typedef struct packed {
    logic [2:0] jump_width;
    logic [4:0] seg1_length;
    logic [3:0] seg2_length;
  } cfg_t;

  typedef struct packed {
    logic falling_edge;
    logic line_idle;
    logic quantum_tick;
  } item_t;

  typedef struct packed {
    logic              sample_pulse;
    logic              write_pulse;
    logic [2:0]        segment;
    logic signed [5:0] phase_offset;
    logic [4:0]        quantum_index;
  } result_t;

endpackage

FILE: design/cbt_ifs.sv
interface cbt_in_if;
  logic valid;
  logic ready;
  logic falling_edge;
  logic line_idle;
  logic quantum_tick;

  modport source (output valid, output falling_edge, output line_idle,
                  output quantum_tick, input ready);
  modport sink (input valid, input falling_edge, input line_idle,
                input quantum_tick, output ready);
endinterface

interface cbt_out_if;
  logic              valid;
  logic              ready;
  logic              sample_pulse;
  logic              write_pulse;
  logic [2:0]        segment;
  logic signed [5:0] phase_offset;
  logic [4:0]        quantum_index;

  modport source (output valid, output sample_pulse, output write_pulse,
                  output segment, output phase_offset, output quantum_index,
                  input ready);
  modport sink (input valid, input sample_pulse, input write_pulse,
                input segment, input phase_offset, input quantum_index,
                output ready);
endinterface

FILE: design/cbt_cfg.sv
module cbt_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cbt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cbt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cbt_pkg::cfg_t                   cfg
);

  cbt_pkg::cfg_t cfg_next;
  logic [2:0]    jw_raw;
  logic [4:0]    s1_raw;
  logic [3:0]    s2_raw;

  // saturate each written value into its legal range
  always_comb begin
    jw_raw   = cfg_data[2:0];
    s1_raw   = cfg_data[4:0];
    s2_raw   = cfg_data[3:0];
    cfg_next = cfg;
    if (cfg_we) begin
      unique case (cfg_index)
        cbt_pkg::CFG_JUMP_WIDTH: begin
          if (jw_raw < cbt_pkg::JUMP_WIDTH_MIN) cfg_next.jump_width = cbt_pkg::JUMP_WIDTH_MIN;
          else if (jw_raw > cbt_pkg::JUMP_WIDTH_MAX) cfg_next.jump_width = cbt_pkg::JUMP_WIDTH_MAX;
          else cfg_next.jump_width = jw_raw;
        end
        cbt_pkg::CFG_SEG1_LENGTH: begin
          if (s1_raw < cbt_pkg::SEG1_LENGTH_MIN) cfg_next.seg1_length = cbt_pkg::SEG1_LENGTH_MIN;
          else if (s1_raw > cbt_pkg::SEG1_LENGTH_MAX) cfg_next.seg1_length = cbt_pkg::SEG1_LENGTH_MAX;
          else cfg_next.seg1_length = s1_raw;
        end
        cbt_pkg::CFG_SEG2_LENGTH: begin
          if (s2_raw < cbt_pkg::SEG2_LENGTH_MIN) cfg_next.seg2_length = cbt_pkg::SEG2_LENGTH_MIN;
          else if (s2_raw > cbt_pkg::SEG2_LENGTH_MAX) cfg_next.seg2_length = cbt_pkg::SEG2_LENGTH_MAX;
          else cfg_next.seg2_length = s2_raw;
        end
        default: begin
          cfg_next = cfg;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.jump_width  <= cbt_pkg::JUMP_WIDTH_RST;
      cfg.seg1_length <= cbt_pkg::SEG1_LENGTH_RST;
      cfg.seg2_length <= cbt_pkg::SEG2_LENGTH_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

FILE: design/cbt_core.sv
module cbt_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  cbt_pkg::item_t   item,
  input  cbt_pkg::cfg_t    cfg,
  output cbt_pkg::result_t result
);

  logic [2:0]        present_segment, present_segment_next;
  logic [2:0]        upcoming_segment, upcoming_segment_next;
  logic [4:0]        bit_quanta_count, bit_quanta_count_next;
  logic [4:0]        first_seg_count, first_seg_count_next;
  logic [4:0]        second_seg_count, second_seg_count_next;
  logic signed [5:0] phase_error_reg, phase_error_reg_next;
  logic [2:0]        adjust_amount, adjust_amount_next;
  logic              sample_flag, sample_flag_next;
  logic              write_flag, write_flag_next;
  logic              hard_sync_pending, hard_sync_pending_next;
  logic              resync_pending, resync_pending_next;
  logic              resync_allowed, resync_allowed_next;

  logic [2:0]        up;
  logic signed [6:0] pe_w;
  logic signed [6:0] mag_w;
  logic signed [6:0] jw_w;
  logic signed [6:0] thr1;
  logic signed [6:0] thr2;
  logic [4:0]        fsc_new;
  logic [4:0]        ssc_new;
  logic signed [6:0] pe_seg2;

  assign pe_w  = {phase_error_reg[5], phase_error_reg};
  assign mag_w = -pe_w;
  assign jw_w  = $signed({4'b0000, cfg.jump_width});
  assign thr1  = $signed({2'b00, cfg.seg1_length}) - 7'sd1;
  assign thr2  = $signed({3'b000, cfg.seg2_length}) - 7'sd1;

  always_comb begin
    hard_sync_pending_next = hard_sync_pending | (item.falling_edge & item.line_idle);
    resync_pending_next    = resync_pending | (item.falling_edge & ~item.line_idle);
    resync_allowed_next    = resync_allowed;
    adjust_amount_next     = adjust_amount;
    present_segment_next   = present_segment;
    upcoming_segment_next  = upcoming_segment;
    bit_quanta_count_next  = bit_quanta_count;
    first_seg_count_next   = first_seg_count;
    second_seg_count_next  = second_seg_count;
    phase_error_reg_next   = phase_error_reg;
    sample_flag_next       = sample_flag;
    write_flag_next        = write_flag;
    up                     = upcoming_segment;
    fsc_new                = first_seg_count + 5'd1;
    ssc_new                = second_seg_count + 5'd1;
    pe_seg2                = 7'sd0;

    if (item.quantum_tick) begin
      // apply a pending request; hard sync wins and leaves any resync queued
      if (hard_sync_pending_next) begin
        up = cbt_pkg::SEG_SYNC;
        hard_sync_pending_next = 1'b0;
      end else if (resync_pending_next) begin
        if (resync_allowed) begin
          if (present_segment == cbt_pkg::SEG_TSEG1) begin
            adjust_amount_next  = (pe_w < jw_w) ? pe_w[2:0] : cfg.jump_width;
            up                  = cbt_pkg::SEG_LONG1;
            resync_allowed_next = 1'b0;
          end else if (present_segment == cbt_pkg::SEG_TSEG2) begin
            adjust_amount_next  = (mag_w < jw_w) ? mag_w[2:0] : cfg.jump_width;
            up                  = (mag_w <= jw_w) ? cbt_pkg::SEG_SYNC : cbt_pkg::SEG_SHORT2;
            resync_allowed_next = 1'b0;
          end
        end
        resync_pending_next = 1'b0;
      end

      // advance one quantum
      upcoming_segment_next = up;
      unique case (up)
        cbt_pkg::SEG_TSEG1: begin
          bit_quanta_count_next = bit_quanta_count + 5'd1;
          if (present_segment == cbt_pkg::SEG_SYNC) begin
            fsc_new              = 5'd0;
            present_segment_next = cbt_pkg::SEG_TSEG1;
          end
          first_seg_count_next = fsc_new;
          write_flag_next      = 1'b0;
          sample_flag_next     = 1'b0;
          phase_error_reg_next = $signed({1'b0, bit_quanta_count_next});
          if ($signed({2'b00, fsc_new}) >= thr1) upcoming_segment_next = cbt_pkg::SEG_TSEG2;
        end
        cbt_pkg::SEG_LONG1: begin
          present_segment_next  = cbt_pkg::SEG_LONG1;
          bit_quanta_count_next = bit_quanta_count + 5'd1;
          first_seg_count_next  = fsc_new;
          write_flag_next       = 1'b0;
          sample_flag_next      = 1'b0;
          if ($signed({2'b00, fsc_new}) >= thr1 + $signed({4'b0000, adjust_amount_next}))
            upcoming_segment_next = cbt_pkg::SEG_TSEG2;
        end
        cbt_pkg::SEG_TSEG2: begin
          bit_quanta_count_next = bit_quanta_count + 5'd1;
          if (present_segment == cbt_pkg::SEG_TSEG1 ||
              present_segment == cbt_pkg::SEG_LONG1) begin
            sample_flag_next     = 1'b1;
            ssc_new              = 5'd0;
            present_segment_next = cbt_pkg::SEG_TSEG2;
          end else begin
            sample_flag_next = 1'b0;
          end
          second_seg_count_next = ssc_new;
          write_flag_next       = 1'b0;
          pe_seg2 = $signed({2'b00, ssc_new}) - $signed({3'b000, cfg.seg2_length});
          phase_error_reg_next  = pe_seg2[5:0];
          if ($signed({2'b00, ssc_new}) >= thr2) upcoming_segment_next = cbt_pkg::SEG_SYNC;
        end
        cbt_pkg::SEG_SHORT2: begin
          present_segment_next  = cbt_pkg::SEG_SHORT2;
          bit_quanta_count_next = bit_quanta_count + 5'd1;
          second_seg_count_next = ssc_new;
          write_flag_next       = 1'b0;
          sample_flag_next      = 1'b0;
          // a negative threshold ends the shortened segment at once
          if ($signed({2'b00, ssc_new}) >= thr2 - $signed({4'b0000, adjust_amount_next}))
            upcoming_segment_next = cbt_pkg::SEG_SYNC;
        end
        default: begin
          write_flag_next       = 1'b1;
          sample_flag_next      = 1'b0;
          resync_allowed_next   = 1'b1;
          bit_quanta_count_next = 5'd0;
          adjust_amount_next    = 3'd0;
          phase_error_reg_next  = 6'sd0;
          present_segment_next  = cbt_pkg::SEG_SYNC;
          upcoming_segment_next = cbt_pkg::SEG_TSEG1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_segment   <= cbt_pkg::SEG_SYNC;
      upcoming_segment  <= cbt_pkg::SEG_SYNC;
      bit_quanta_count  <= 5'd0;
      first_seg_count   <= 5'd0;
      second_seg_count  <= 5'd0;
      phase_error_reg   <= 6'sd0;
      adjust_amount     <= 3'd0;
      sample_flag       <= 1'b0;
      write_flag        <= 1'b0;
      hard_sync_pending <= 1'b0;
      resync_pending    <= 1'b0;
      resync_allowed    <= 1'b1;
    end else if (step) begin
      present_segment   <= present_segment_next;
      upcoming_segment  <= upcoming_segment_next;
      bit_quanta_count  <= bit_quanta_count_next;
      first_seg_count   <= first_seg_count_next;
      second_seg_count  <= second_seg_count_next;
      phase_error_reg   <= phase_error_reg_next;
      adjust_amount     <= adjust_amount_next;
      sample_flag       <= sample_flag_next;
      write_flag        <= write_flag_next;
      hard_sync_pending <= hard_sync_pending_next;
      resync_pending    <= resync_pending_next;
      resync_allowed    <= resync_allowed_next;
    end
  end

  assign result.sample_pulse  = sample_flag;
  assign result.write_pulse   = write_flag;
  assign result.segment       = present_segment;
  assign result.phase_offset  = phase_error_reg;
  assign result.quantum_index = bit_quanta_count;

  a_write_in_sync: assert property (@(posedge clk) disable iff (rst)
    write_flag |-> present_segment == cbt_pkg::SEG_SYNC)
    else $error("writing point outside sync segment");

  a_sample_in_tseg2: assert property (@(posedge clk) disable iff (rst)
    sample_flag |-> present_segment == cbt_pkg::SEG_TSEG2)
    else $error("sample point outside phase segment two");

  a_sync_count_zero: assert property (@(posedge clk) disable iff (rst)
    present_segment == cbt_pkg::SEG_SYNC |-> bit_quanta_count == 5'd0)
    else $error("quantum count not cleared in sync segment");

  a_resync_use_on_tick: assert property (@(posedge clk) disable iff (rst)
    $fell(resync_allowed) |-> $past(step && item.quantum_tick))
    else $error("resync consumed without a quantum tick");

  a_adjust_bound: assert property (@(posedge clk) disable iff (rst)
    adjust_amount <= cbt_pkg::JUMP_WIDTH_MAX)
    else $error("phase adjustment exceeds jump width bound");

endmodule

FILE: design/can_bit_timing_sync_top.sv
// Channel   Dir  Payload                                                    Handshake
// -------   ---  ---------------------------------------------------------  ----------
// in_ch     in   falling_edge, line_idle, quantum_tick                      valid/ready
// out_ch    out  sample_pulse, write_pulse, segment, phase_offset,          valid/ready
//                quantum_index
// cfg       in   cfg_index, cfg_data (0 jump width, 1 seg1, 2 seg2)          cfg_we
//
// One word in gives one word out. The timing state updates in the cycle a
// word is accepted and the result appears on out_ch on the next cycle.
// Throughput is one word per clock while out_ch is not stalled.
// A stalled result holds out_ch while the next word is taken in the same
// cycle the result leaves, so no bubbles under continuous flow.
// rst is synchronous: sync segment, counts zero, registers at defaults.
module can_bit_timing_sync_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cbt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cbt_pkg::CFG_DATA_W-1:0]  cfg_data,
  cbt_in_if.sink                          in_ch,
  cbt_out_if.source                       out_ch
);

  cbt_pkg::cfg_t    cfg;
  cbt_pkg::item_t   item;
  cbt_pkg::result_t result;
  logic             out_valid;
  logic             accept;

  // Take a new word whenever the result slot is empty or draining.
  assign in_ch.ready = ~out_valid | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;

  assign item.falling_edge = in_ch.falling_edge;
  assign item.line_idle    = in_ch.line_idle;
  assign item.quantum_tick = in_ch.quantum_tick;

  cbt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The state registers in the core are the result register: they only
  // advance on accept, which only happens once the previous word is taken.
  cbt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Hold valid until the sink takes the word; reload on every accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.sample_pulse  = result.sample_pulse;
  assign out_ch.write_pulse   = result.write_pulse;
  assign out_ch.segment       = result.segment;
  assign out_ch.phase_offset  = result.phase_offset;
  assign out_ch.quantum_index = result.quantum_index;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !accept)
    else $error("accepted a word over a pending result");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept))
    else $error("result appeared without an accepted word");

endmodule

FILE: dv/tb_can_bit_timing_sync_top.sv
`timescale 1ns / 1ps

module tb_can_bit_timing_sync_top;

  // The package names only the three live registers; index 3 decodes to nothing.
  localparam logic [cbt_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int REPORT_MAX   = 10;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [cbt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [cbt_pkg::CFG_DATA_W-1:0]  cfg_data;

  cbt_in_if  in_ch ();
  cbt_out_if out_ch ();

  can_bit_timing_sync_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // Gap and stall odds in percent, changed from phase to phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int cycle_count = 0;
  int mismatches  = 0;

  // Timing words the block still owes, oldest first.
  cbt_pkg::result_t expected_timing[$];

  // ---------------------------------------------------------------------------
  // Bit timing predictor: own copy of the registers and of the segment state.
  // Everything is kept as int so that the signed phase error and the
  // thresholds compare the way the block is meant to compare them.
  // ---------------------------------------------------------------------------
  int jump_w    = int'(cbt_pkg::JUMP_WIDTH_RST);
  int seg1_len  = int'(cbt_pkg::SEG1_LENGTH_RST);
  int seg2_len  = int'(cbt_pkg::SEG2_LENGTH_RST);

  logic [2:0] cur_seg = cbt_pkg::SEG_SYNC;
  logic [2:0] nxt_seg = cbt_pkg::SEG_SYNC;
  int  quanta     = 0;
  int  seg1_cnt   = 0;
  int  seg2_cnt   = 0;
  int  phase_err  = 0;
  int  stretch    = 0;
  bit  sample_q   = 1'b0;
  bit  write_q    = 1'b0;
  bit  hard_req   = 1'b0;
  bit  resync_req = 1'b0;
  bit  resync_ok  = 1'b1;

  function automatic int clamp_range(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic cbt_pkg::result_t advance_bit_timing(cbt_pkg::item_t w);
    int mag;
    cbt_pkg::result_t r;
    // Latch the edge first: hard sync on an idle bus, resync otherwise.
    if (w.falling_edge) begin
      if (w.line_idle) hard_req = 1'b1;
      else resync_req = 1'b1;
    end
    if (w.quantum_tick) begin
      // Hard sync wins and leaves any resync request for the next quantum.
      if (hard_req) begin
        nxt_seg  = cbt_pkg::SEG_SYNC;
        hard_req = 1'b0;
      end else if (resync_req) begin
        // One SJW-limited resize per bit, and only from TSEG1 or TSEG2.
        if (resync_ok) begin
          if (cur_seg == cbt_pkg::SEG_TSEG1) begin
            stretch   = (phase_err < jump_w) ? phase_err : jump_w;
            nxt_seg   = cbt_pkg::SEG_LONG1;
            resync_ok = 1'b0;
          end else if (cur_seg == cbt_pkg::SEG_TSEG2) begin
            mag       = -phase_err;
            stretch   = (mag < jump_w) ? mag : jump_w;
            nxt_seg   = (mag <= jump_w) ? cbt_pkg::SEG_SYNC : cbt_pkg::SEG_SHORT2;
            resync_ok = 1'b0;
          end
        end
        resync_req = 1'b0;
      end

      case (nxt_seg)
        cbt_pkg::SEG_TSEG1: begin
          quanta = (quanta + 1) & 31;
          if (cur_seg == cbt_pkg::SEG_SYNC) begin
            seg1_cnt = 0;
            cur_seg  = cbt_pkg::SEG_TSEG1;
          end else begin
            seg1_cnt = (seg1_cnt + 1) & 31;
          end
          write_q   = 1'b0;
          sample_q  = 1'b0;
          phase_err = quanta;
          if (seg1_cnt >= seg1_len - 1) nxt_seg = cbt_pkg::SEG_TSEG2;
        end
        cbt_pkg::SEG_LONG1: begin
          cur_seg  = cbt_pkg::SEG_LONG1;
          quanta   = (quanta + 1) & 31;
          seg1_cnt = (seg1_cnt + 1) & 31;
          write_q  = 1'b0;
          sample_q = 1'b0;
          if (seg1_cnt >= seg1_len - 1 + stretch) nxt_seg = cbt_pkg::SEG_TSEG2;
        end
        cbt_pkg::SEG_TSEG2: begin
          quanta = (quanta + 1) & 31;
          if (cur_seg == cbt_pkg::SEG_TSEG1 || cur_seg == cbt_pkg::SEG_LONG1) begin
            sample_q = 1'b1;
            seg2_cnt = 0;
            cur_seg  = cbt_pkg::SEG_TSEG2;
          end else begin
            sample_q = 1'b0;
            seg2_cnt = (seg2_cnt + 1) & 31;
          end
          write_q   = 1'b0;
          phase_err = seg2_cnt - seg2_len;
          if (seg2_cnt >= seg2_len - 1) nxt_seg = cbt_pkg::SEG_SYNC;
        end
        cbt_pkg::SEG_SHORT2: begin
          cur_seg  = cbt_pkg::SEG_SHORT2;
          quanta   = (quanta + 1) & 31;
          seg2_cnt = (seg2_cnt + 1) & 31;
          write_q  = 1'b0;
          sample_q = 1'b0;
          // A negative threshold ends the shortened segment at once.
          if (seg2_cnt >= seg2_len - 1 - stretch) nxt_seg = cbt_pkg::SEG_SYNC;
        end
        default: begin
          write_q   = 1'b1;
          sample_q  = 1'b0;
          resync_ok = 1'b1;
          quanta    = 0;
          stretch   = 0;
          phase_err = 0;
          cur_seg   = cbt_pkg::SEG_SYNC;
          nxt_seg   = cbt_pkg::SEG_TSEG1;
        end
      endcase
    end
    r.sample_pulse  = sample_q;
    r.write_pulse   = write_q;
    r.segment       = cur_seg;
    r.phase_offset  = phase_err[5:0];
    r.quantum_index = quanta[4:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Write one register; drop the enable on the following falling edge.
  task automatic write_reg(input logic [cbt_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [cbt_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      cbt_pkg::CFG_JUMP_WIDTH:
        jump_w = clamp_range(int'(data) & 7, int'(cbt_pkg::JUMP_WIDTH_MIN),
                             int'(cbt_pkg::JUMP_WIDTH_MAX));
      cbt_pkg::CFG_SEG1_LENGTH:
        seg1_len = clamp_range(int'(data) & 31, int'(cbt_pkg::SEG1_LENGTH_MIN),
                               int'(cbt_pkg::SEG1_LENGTH_MAX));
      cbt_pkg::CFG_SEG2_LENGTH:
        seg2_len = clamp_range(int'(data) & 15, int'(cbt_pkg::SEG2_LENGTH_MIN),
                               int'(cbt_pkg::SEG2_LENGTH_MAX));
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one word, with random gaps ahead of it, and predict its result once
  // the block takes it. Valid stays high afterwards so back-to-back words
  // flow without a bubble; the next call or a drain decides what follows.
  task automatic send_word(input logic fall, input logic idle, input logic tick);
    cbt_pkg::item_t w;
    w = '{falling_edge: fall, line_idle: idle, quantum_tick: tick};
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.falling_edge <= w.falling_edge;
    in_ch.line_idle    <= w.line_idle;
    in_ch.quantum_tick <= w.quantum_tick;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_timing.push_back(advance_bit_timing(w));
  endtask

  // Hold the input quiet until every predicted word has come back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_timing.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out-of-range and masked writes, the dead index, then the start of one short bit.
  task automatic test_register_limits();
    write_reg(cbt_pkg::CFG_JUMP_WIDTH, 5'd0);     // zero saturates up to 1
    write_reg(cbt_pkg::CFG_SEG1_LENGTH, 5'd0);    // zero saturates up to 1
    write_reg(cbt_pkg::CFG_SEG2_LENGTH, 5'd31);   // masked to 15, saturates to 8
    write_reg(CFG_UNUSED, 5'd31);                 // no register here: ignored
    write_reg(cbt_pkg::CFG_JUMP_WIDTH, 5'd15);    // masked to 7, saturates to 4
    // sync, one-quantum TSEG1, first two quanta of TSEG2
    repeat (4) send_word(1'b0, 1'b0, 1'b1);
  endtask

  // Walk the special cases of hard sync and resync.
  // Enters with jump width 4, seg1 1, seg2 8, two quanta into TSEG2.
  task automatic test_sync_requests();
    send_word(1'b1, 1'b0, 1'b0);  // edge without tick: latch only
    send_word(1'b0, 1'b0, 1'b1);  // resync late in TSEG2: shortened seg2
    send_word(1'b1, 1'b0, 1'b1);  // resync in shortened seg2: dropped
    send_word(1'b0, 1'b0, 1'b1);  // sync segment
    send_word(1'b1, 1'b1, 1'b0);  // hard sync latched
    send_word(1'b1, 1'b0, 1'b0);  // resync latched behind it
    send_word(1'b0, 1'b0, 1'b1);  // hard sync wins, back to sync
    send_word(1'b0, 1'b0, 1'b1);  // leftover resync lands in sync: dropped
    send_word(1'b1, 1'b0, 1'b1);  // resync in TSEG1: lengthened seg1
    send_word(1'b0, 1'b0, 1'b1);  // sample point
    send_word(1'b1, 1'b0, 1'b1);  // second resync in the same bit: dropped
    send_word(1'b1, 1'b1, 1'b1);  // hard sync with its own tick
    send_word(1'b0, 1'b0, 1'b1);  // TSEG1
    send_word(1'b0, 1'b0, 1'b1);  // TSEG2, full phase error
    send_word(1'b1, 1'b0, 1'b1);  // shortened seg2 again
    // Shrink seg2 under the shortened segment so its threshold goes negative.
    drain_results();
    write_reg(cbt_pkg::CFG_SEG2_LENGTH, 5'd1);
    send_word(1'b0, 1'b0, 1'b1);  // ends at once
    send_word(1'b0, 1'b0, 1'b1);  // sync
    send_word(1'b0, 1'b0, 1'b1);  // TSEG1
    send_word(1'b0, 1'b0, 1'b1);  // TSEG2, error within jump width
    send_word(1'b1, 1'b0, 1'b1);  // resync within jump width: straight to sync
    drain_results();
  endtask

  // Random traffic under one register setting and one idling pattern.
  // Ticks dominate so bits run to completion; edges land in every segment.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [cbt_pkg::CFG_DATA_W-1:0] jw_data,
                                     input logic [cbt_pkg::CFG_DATA_W-1:0] s1_data,
                                     input logic [cbt_pkg::CFG_DATA_W-1:0] s2_data,
                                     input int words, input bit hold_mid);
    int edge_pct;
    drain_results();
    write_reg(cbt_pkg::CFG_JUMP_WIDTH, jw_data);
    write_reg(cbt_pkg::CFG_SEG1_LENGTH, s1_data);
    write_reg(cbt_pkg::CFG_SEG2_LENGTH, s2_data);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    edge_pct       = $urandom_range(5, 25);
    for (int i = 0; i < words; i++) begin
      // Pause the sender until the block has nothing left in flight.
      if (hold_mid && i == words / 2) drain_results();
      send_word($urandom_range(99) < edge_pct, $urandom_range(99) < 15,
                $urandom_range(99) < 80);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted word with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cbt_pkg::result_t got;
    cbt_pkg::result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{sample_pulse: out_ch.sample_pulse, write_pulse: out_ch.write_pulse,
              segment: out_ch.segment, phase_offset: out_ch.phase_offset,
              quantum_index: out_ch.quantum_index};
      if (expected_timing.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected word sp=%0b wp=%0b seg=%0d err=%0d idx=%0d", $realtime,
                   got.sample_pulse, got.write_pulse, got.segment,
                   got.phase_offset, got.quantum_index);
      end else begin
        want = expected_timing.pop_front();
        if (got.sample_pulse  !== want.sample_pulse  ||
            got.write_pulse   !== want.write_pulse   ||
            got.segment       !== want.segment       ||
            got.phase_offset  !== want.phase_offset  ||
            got.quantum_index !== want.quantum_index) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: expected sp=%0b wp=%0b seg=%0d err=%0d idx=%0d,",
                     $realtime, want.sample_pulse, want.write_pulse, want.segment,
                     want.phase_offset, want.quantum_index,
                     " got sp=%0b wp=%0b seg=%0d err=%0d idx=%0d",
                     got.sample_pulse, got.write_pulse, got.segment,
                     got.phase_offset, got.quantum_index);
        end
      end
    end
  end

  // Receiver: stall at random, odds set by the current phase.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_can_bit_timing_sync_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.falling_edge = 1'b0;
    in_ch.line_idle    = 1'b0;
    in_ch.quantum_tick = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under moderate gaps on both sides.
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    test_register_limits();
    test_sync_requests();

    // Random part: extremes first, then mixed settings, each idling pattern twice.
    test_random_traffic(0, 0, 5'd1, 5'd1, 5'd1, 215, 1'b0);
    test_random_traffic(84, 0, 5'd4, 5'd16, 5'd8, 215, 1'b0);
    test_random_traffic(0, 84, 5'd2, 5'd8, 5'd2, 215, 1'b1);
    test_random_traffic(38, 38, 5'd3, 5'd5, 5'd4, 215, 1'b0);
    test_random_traffic(0, 0, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                        5'($urandom_range(0, 31)), 215, 1'b0);
    test_random_traffic(84, 0, 5'($urandom_range(1, 4)), 5'($urandom_range(1, 16)),
                        5'($urandom_range(1, 8)), 215, 1'b0);
    test_random_traffic(0, 84, 5'($urandom_range(1, 4)), 5'($urandom_range(1, 16)),
                        5'($urandom_range(1, 8)), 215, 1'b0);
    test_random_traffic(38, 38, 5'd4, 5'd1, 5'd8, 215, 1'b0);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_can_bit_timing_sync_top: PASS");
    end else begin
      $display("tb_can_bit_timing_sync_top: FAIL");
    end
    $finish;
  end

endmodule
